/* rtl/hed_pkg.sv */
`default_nettype none

package hed_pkg;

  localparam int unsigned PENDING_MAX_DEF = 8;
  localparam int unsigned CMDQ_DEPTH      = 4;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_of_run;
    logic       end_of_output;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NAMED,
    PH_NUM
  } phase_t;

  typedef enum logic [1:0] {
    ENT_LT,
    ENT_GT,
    ENT_QUOT,
    ENT_AMP
  } ent_id_t;

  typedef enum logic [1:0] {
    OP_EMIT,
    OP_EMIT_CLR,
    OP_APPEND,
    OP_FLUSH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
    logic       mark;
    logic       eot;
  } cmd_t;

  typedef enum logic {
    BK_RUN,
    BK_FLUSH
  } bk_state_t;

  function automatic logic [7:0] ent_char(input ent_id_t e, input logic [2:0] k);
    logic [47:0] s;
    logic [47:0] sh;
    case (e)
      ENT_LT:   s = {"&lt;", 16'h0000};
      ENT_GT:   s = {"&gt;", 16'h0000};
      ENT_QUOT: s = "&quot;";
      ENT_AMP:  s = {"&amp;", 8'h00};
      default:  s = '0;
    endcase
    sh = s << {k, 3'b000};
    return sh[47:40];
  endfunction

  function automatic logic [2:0] ent_len(input ent_id_t e);
    case (e)
      ENT_LT:   return 3'd4;
      ENT_GT:   return 3'd4;
      ENT_QUOT: return 3'd6;
      ENT_AMP:  return 3'd5;
      default:  return 3'd4;
    endcase
  endfunction

  function automatic logic [7:0] ent_value(input ent_id_t e);
    case (e)
      ENT_LT:   return 8'h3C;
      ENT_GT:   return 8'h3E;
      ENT_QUOT: return 8'h22;
      ENT_AMP:  return 8'h26;
      default:  return 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

/* rtl/hed_front.sv */
`default_nettype none

module hed_front import hed_pkg::*; #(
  parameter int unsigned PENDING_MAX = PENDING_MAX_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          q_push,
  output cmd_t          q_wdata,
  input  wire logic     q_full
);

  localparam int unsigned CW = $clog2(PENDING_MAX + 1);

  phase_t     phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0] num_r, num_nxt;
  ent_id_t    ent_r, ent_nxt;

  cmd_t       stg_r [3];
  logic [1:0] stg_cnt_r;

  cmd_t       c1, c2, c3;
  logic       have1, have3, mism, hit;
  ent_id_t    hit_e;
  logic       accept;
  logic [7:0] b;
  logic       eot;

  assign b      = in_data.byte_in;
  assign eot    = in_data.end_of_text;
  assign q_push  = (stg_cnt_r != 2'd0) && !q_full;
  assign q_wdata = stg_r[0];
  assign in_ready = (stg_cnt_r == 2'd0) || ((stg_cnt_r == 2'd1) && q_push);
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    ent_nxt   = ent_r;
    mism      = 1'b0;
    have1     = 1'b0;
    have3     = 1'b0;
    hit       = 1'b0;
    hit_e     = ENT_LT;
    c1 = '{op: OP_FLUSH, data: b, mark: 1'b0, eot: eot};
    c2 = '{op: OP_EMIT,  data: b, mark: 1'b0, eot: eot};
    c3 = '{op: OP_FLUSH, data: b, mark: 1'b0, eot: eot};

    for (int e = 0; e < 4; e++) begin
      if (ent_char(ent_id_t'(e[1:0]), 3'd1) == b) begin
        hit   = 1'b1;
        hit_e = ent_id_t'(e[1:0]);
      end
    end

    case (phase_r)
      PH_NAMED: begin
        if (cnt_r == CW'(1)) begin
          if (b == CH_HASH) begin
            c2.op     = OP_APPEND;
            phase_nxt = PH_NUM;
            cnt_nxt   = CW'(2);
            num_nxt   = '0;
          end else if (hit) begin
            c2.op   = OP_APPEND;
            ent_nxt = hit_e;
            cnt_nxt = CW'(2);
          end else begin
            mism = 1'b1;
          end
        end else if (ent_char(ent_r, cnt_r[2:0]) == b) begin
          if (cnt_r + CW'(1) == CW'(ent_len(ent_r))) begin
            c2.op     = OP_EMIT_CLR;
            c2.data   = ent_value(ent_r);
            phase_nxt = PH_IDLE;
            cnt_nxt   = '0;
          end else begin
            c2.op   = OP_APPEND;
            cnt_nxt = cnt_r + CW'(1);
          end
        end else begin
          mism = 1'b1;
        end
      end
      PH_NUM: begin
        if (b == CH_SEMI) begin
          c2.op     = OP_EMIT_CLR;
          c2.data   = num_r;
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
          num_nxt   = '0;
        end else if ((b inside {[CH_0:CH_9]}) && (cnt_r < CW'(PENDING_MAX))) begin
          c2.op   = OP_APPEND;
          cnt_nxt = cnt_r + CW'(1);
          num_nxt = num_r * 8'd10 + (b - CH_0);
        end else begin
          mism = 1'b1;
        end
      end
      default: ;
    endcase

    if ((phase_r != PH_NAMED && phase_r != PH_NUM) || mism) begin
      have1   = mism;
      num_nxt = '0;
      if (b == CH_AMP) begin
        c2.op     = OP_APPEND;
        phase_nxt = PH_NAMED;
        cnt_nxt   = CW'(1);
      end else begin
        c2.op     = OP_EMIT;
        c2.data   = b;
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
      end
    end

    if (eot) begin
      have3     = (cnt_nxt != '0);
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
      num_nxt   = '0;
    end

    if (have3) begin
      c3.mark = 1'b1;
    end else if (c2.op == OP_EMIT || c2.op == OP_EMIT_CLR) begin
      c2.mark = 1'b1;
    end else if (have1) begin
      c1.mark = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      num_r   <= '0;
      ent_r   <= ENT_LT;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      num_r   <= num_nxt;
      ent_r   <= ent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_cnt_r <= 2'd0;
    end else if (accept) begin
      stg_cnt_r <= 2'd1 + {1'b0, have1} + {1'b0, have3};
    end else if (q_push) begin
      stg_cnt_r <= stg_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r[0] <= have1 ? c1 : c2;
      stg_r[1] <= have1 ? c2 : c3;
      stg_r[2] <= c3;
    end else if (q_push) begin
      stg_r[0] <= stg_r[1];
      stg_r[1] <= stg_r[2];
    end
  end

endmodule

`default_nettype wire

/* rtl/hed_cmd_fifo.sv */
`default_nettype none

module hed_cmd_fifo import hed_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t wdata,
  output logic      full,
  input  wire logic pop,
  output cmd_t      rdata,
  output logic      empty
);

  localparam int unsigned DEPTH = CMDQ_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  cmd_t          slot_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW + 1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      cnt_r <= cnt_r + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/hed_back.sv */
`default_nettype none

module hed_back import hed_pkg::*; #(
  parameter int unsigned PENDING_MAX = PENDING_MAX_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cmd_t      q_rdata,
  input  wire logic      q_empty,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int unsigned CW = $clog2(PENDING_MAX + 1);
  localparam int unsigned IW = $clog2(PENDING_MAX);

  bk_state_t     state_r, state_nxt;
  logic [7:0]    hold_r [PENDING_MAX];
  logic [CW-1:0] bcnt_r, bcnt_nxt;
  logic [IW-1:0] rd_r, rd_nxt;
  logic          mark_r, mark_nxt;
  logic          eot_r, eot_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;
  logic          wr_en;
  logic          out_free;
  logic          fl_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign fl_last   = (CW'(rd_r) + CW'(1) == bcnt_r);

  always_comb begin
    state_nxt     = state_r;
    bcnt_nxt      = bcnt_r;
    rd_nxt        = rd_r;
    mark_nxt      = mark_r;
    eot_nxt       = eot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;

    case (state_r)
      BK_RUN: begin
        if (!q_empty) begin
          case (q_rdata.op)
            OP_APPEND: begin
              wr_en    = 1'b1;
              bcnt_nxt = bcnt_r + CW'(1);
              q_pop    = 1'b1;
            end
            OP_EMIT, OP_EMIT_CLR: begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{byte_out: q_rdata.data,
                                  last_of_run: q_rdata.mark,
                                  end_of_output: q_rdata.mark && q_rdata.eot};
                q_pop = 1'b1;
                if (q_rdata.op == OP_EMIT_CLR) begin
                  bcnt_nxt = '0;
                end
              end
            end
            OP_FLUSH: begin
              q_pop = 1'b1;
              if (bcnt_r != '0) begin
                mark_nxt  = q_rdata.mark;
                eot_nxt   = q_rdata.eot;
                rd_nxt    = '0;
                state_nxt = BK_FLUSH;
              end
            end
            default: ;
          endcase
        end
      end
      BK_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{byte_out: hold_r[rd_r],
                            last_of_run: mark_r && fl_last,
                            end_of_output: mark_r && eot_r && fl_last};
          rd_nxt = rd_r + IW'(1);
          if (fl_last) begin
            bcnt_nxt  = '0;
            state_nxt = BK_RUN;
          end
        end
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      bcnt_r      <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bcnt_r      <= bcnt_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mark_r     <= mark_nxt;
    eot_r      <= eot_nxt;
    out_data_r <= out_data_nxt;
    if (wr_en) begin
      hold_r[bcnt_r[IW-1:0]] <= q_rdata.data;
    end
  end

endmodule

`default_nettype wire

/* rtl/html_entity_decoder_unit.sv */
// Channel  Direction  Beat type    Handshake
// in_      input      in_item_t    in_valid / in_ready
// out_     output     out_item_t   out_valid / out_ready
//
// Front: one input beat per cycle, giving one to three commands that enter a four-entry
// command queue one per cycle unless it is full. Back: one command per cycle outside a
// flush, emits waiting for a free output; a flush starts, then sends the held bytes one
// per cycle as taken. A result passes staging registers, a queue slot and the output
// register; input stalls while more than one command is staged, or one is and the queue is full.
// Reset (rst_n low, synchronous) empties the queue and drops any open entity.
`default_nettype none

module html_entity_decoder_unit import hed_pkg::*; #(
  parameter int unsigned PENDING_MAX = PENDING_MAX_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wdata, q_rdata;

  hed_front #(.PENDING_MAX(PENDING_MAX)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  hed_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  hed_back #(.PENDING_MAX(PENDING_MAX)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* rtl/hed_checker.sv */
`default_nettype none

module hed_port_checker import hed_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out beat dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out beat changed while stalled");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_output |-> out_data.last_of_run)
    else $error("end of output on a beat that does not close its run");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out beat shown straight after reset");

endmodule

bind html_entity_decoder_unit hed_port_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

/* tb/hed_checker.sv */
`timescale 1ns / 100ps

module hed_checker import hed_pkg::*; #(
  parameter int unsigned PENDING_MAX = PENDING_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        awaited
);

  phase_t      phase;
  logic [7:0]  held [PENDING_MAX];
  int unsigned held_cnt;
  logic [7:0]  num_acc;
  out_item_t   run_q[$];
  out_item_t   decoded_q[$];

  initial begin
    fail_count = 0;
    awaited    = 0;
    phase      = PH_IDLE;
    held_cnt   = 0;
    num_acc    = 8'h00;
  end

  function automatic string ent_text(input ent_id_t e);
    case (e)
      ENT_LT:   return "&lt;";
      ENT_GT:   return "&gt;";
      ENT_QUOT: return "&quot;";
      default:  return "&amp;";
    endcase
  endfunction

  function automatic logic [7:0] ent_code(input ent_id_t e);
    case (e)
      ENT_LT:   return "<";
      ENT_GT:   return ">";
      ENT_QUOT: return "\"";
      default:  return "&";
    endcase
  endfunction

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic put(input logic [7:0] b);
    out_item_t r;
    r.byte_out      = b;
    r.last_of_run   = 1'b0;
    r.end_of_output = 1'b0;
    run_q = {run_q, r};
  endtask

  task automatic flush_held();
    for (int k = 0; k < held_cnt; k++) put(held[k]);
    held_cnt = 0;
    phase    = PH_IDLE;
    num_acc  = 8'h00;
  endtask

  task automatic hold(input logic [7:0] b);
    if (held_cnt < PENDING_MAX) begin
      held[held_cnt] = b;
      held_cnt++;
    end
  endtask

  task automatic open_or_pass(input logic [7:0] b);
    if (b == CH_AMP) begin
      held[0]  = b;
      held_cnt = 1;
      phase    = PH_NAMED;
      num_acc  = 8'h00;
    end else begin
      put(b);
    end
  endtask

  task automatic step_named(input logic [7:0] b);
    string s;
    bit    ok;
    if (held_cnt == 1 && b == CH_HASH) begin
      hold(b);
      phase   = PH_NUM;
      num_acc = 8'h00;
      return;
    end
    for (int e = 0; e < 4; e++) begin
      s  = ent_text(ent_id_t'(e));
      ok = (held_cnt < s.len());
      for (int k = 0; ok && k < held_cnt; k++)
        if (held[k] != s[k]) ok = 1'b0;
      if (ok && s[held_cnt] == b) begin
        if (held_cnt + 1 == s.len()) begin
          held_cnt = 0;
          phase    = PH_IDLE;
          put(ent_code(ent_id_t'(e)));
        end else begin
          hold(b);
        end
        return;
      end
    end
    flush_held();
    open_or_pass(b);
  endtask

  task automatic step_numeric(input logic [7:0] b);
    logic [7:0] v;
    if (b == CH_SEMI) begin
      v        = num_acc;
      held_cnt = 0;
      phase    = PH_IDLE;
      num_acc  = 8'h00;
      put(v);
    end else if (b >= CH_0 && b <= CH_9 && held_cnt < PENDING_MAX) begin
      hold(b);
      num_acc = 8'(num_acc * 8'd10 + (b - CH_0));
    end else begin
      flush_held();
      open_or_pass(b);
    end
  endtask

  task automatic decode_beat(input in_item_t beat);
    run_q.delete();
    case (phase)
      PH_NAMED: step_named(beat.byte_in);
      PH_NUM:   step_numeric(beat.byte_in);
      default: begin
        phase    = PH_IDLE;
        held_cnt = 0;
        open_or_pass(beat.byte_in);
      end
    endcase
    if (beat.end_of_text) flush_held();
    if (run_q.size() > 0) begin
      run_q[run_q.size() - 1].last_of_run   = 1'b1;
      run_q[run_q.size() - 1].end_of_output = beat.end_of_text;
    end
    decoded_q = {decoded_q, run_q};
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) decode_beat(in_data);
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report("unexpected beat", out_data.byte_out, 8'h00);
        end else begin
          want = decoded_q.pop_front();
          if (out_data.byte_out != want.byte_out)
            report("byte_out", out_data.byte_out, want.byte_out);
          if (out_data.last_of_run != want.last_of_run)
            report("last_of_run", 8'(out_data.last_of_run), 8'(want.last_of_run));
          if (out_data.end_of_output != want.end_of_output)
            report("end_of_output", 8'(out_data.end_of_output), 8'(want.end_of_output));
        end
      end
      awaited = decoded_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import hed_pkg::*;

  localparam int unsigned HOLD_START  = 300;
  localparam int unsigned HOLD_LEN    = 150;
  localparam int unsigned QUIET_START = 1200;
  localparam int unsigned QUIET_END   = 1700;
  localparam int          BEAT_TOTAL  = 375;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        awaited;

  int         sent;
  bit         sender_idles;
  logic [7:0] seq[$];

  html_entity_decoder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  hed_checker #(.PENDING_MAX(PENDING_MAX_DEF)) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, one long hold-off, one stretch always ready
  initial begin : receiver
    int unsigned cyc;
    cyc       = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
        out_ready <= 1'b0;
      else if (cyc >= QUIET_START && cyc < QUIET_END)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(0, 99) >= 20);
    end
  end

  function automatic string entity_text(input int e);
    case (e)
      0:       return "&lt;";
      1:       return "&gt;";
      2:       return "&quot;";
      default: return "&amp;";
    endcase
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic eot);
    in_item_t beat;
    if (sender_idles && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    beat.byte_in     = b;
    beat.end_of_text = eot;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++)
      send_beat(s[i], eot_last && (i == s.len() - 1));
  endtask

  task automatic send_seq();
    while (seq.size() > 0) begin
      sender_idles = !(sent >= 150 && sent < 230);
      send_beat(seq.pop_front(), $urandom_range(0, 99) < 4);
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    seq = {seq, b};
  endtask

  task automatic build_token();
    string      s;
    int         pick;
    int         n;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      s = entity_text($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 20) begin
        n = $urandom_range(1, s.len() - 1);
        for (int i = 0; i < n; i++) queue_byte(s[i]);
        queue_byte($urandom_range(0, 1) ? 8'($urandom_range(97, 122))
                                        : 8'($urandom_range(0, 255)));
      end else begin
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
      end
    end else if (pick < 55) begin
      queue_byte(CH_AMP);
      queue_byte(CH_HASH);
      n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(4, 8);
      for (int i = 0; i < n; i++) queue_byte(CH_0 + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 99) < 80) begin
        queue_byte(CH_SEMI);
      end else begin
        case ($urandom_range(0, 2))
          0:       queue_byte("x");
          1:       queue_byte(CH_AMP);
          default: queue_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end else if (pick < 70) begin
      queue_byte(8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      c = 8'($urandom_range(32, 126));
      queue_byte((c == CH_AMP) ? 8'h61 : c);
    end else begin
      queue_byte(CH_AMP);
      case ($urandom_range(0, 5))
        0:       queue_byte("l");
        1:       queue_byte("g");
        2:       queue_byte("q");
        3:       queue_byte("a");
        4:       queue_byte(CH_AMP);
        default: queue_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin : stimulus
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    sent         = 0;
    sender_idles = 1'b1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_text("&lt;", 1'b0);
    send_text("&#;", 1'b0);
    send_text("&#x", 1'b0);
    send_text("&#1234567", 1'b0);
    send_text("&q", 1'b1);
    send_text("&#999;", 1'b1);

    while (sent < BEAT_TOTAL) begin
      build_token();
      send_seq();
    end
    // close the string so nothing stays held
    sender_idles = 1'b1;
    send_beat(".", 1'b1);
    in_valid <= 1'b0;

    while (awaited != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0 && awaited == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/hed_pkg.sv
rtl/hed_front.sv
rtl/hed_cmd_fifo.sv
rtl/hed_back.sv
rtl/html_entity_decoder_unit.sv
rtl/hed_checker.sv
tb/hed_checker.sv
tb/tb_top.sv
